// File: hw/rtl/gdo_pkg.sv
// Shared constants, tables and helper functions for the Gregorian date offset block.
package gdo_pkg;

  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [21:0] DAY_LIMIT   = 22'd3652059;
  localparam logic [17:0] DAYS_400Y   = 18'd146097;
  localparam logic [17:0] DAYS_100Y   = 18'd36524;
  localparam logic [17:0] DAYS_4Y     = 18'd1461;
  localparam logic [17:0] DAYS_1Y     = 18'd365;
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;
  localparam logic [3:0]  LAST_MONTH  = 4'd11;

  function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
    logic [4:0] len;
    unique case (idx)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                    len = 5'd30;
      4'd1:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] mon);
    logic [8:0] d;
    unique case (mon)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic is_leap(input logic [13:0] yr, input logic [6:0] q100);
    logic [13:0] hund;
    hund = 14'(q100) * 14'd100;
    return (yr[1:0] == 2'b00) && ((yr != hund) || (q100[1:0] == 2'b00));
  endfunction

endpackage

// File: hw/rtl/gdo_div100.sv
// Divide a year-sized value by 100 through a reciprocal multiply.
module gdo_div100
  import gdo_pkg::*;
(
  input  logic [13:0] value,
  output logic [6:0]  quot
);

  logic [26:0] prod;

  assign prod = 27'(value) * 27'(RECIP_100);
  assign quot = prod[RECIP_SHIFT+6:RECIP_SHIFT];

endmodule

// File: hw/rtl/gdo_sub_unit.sv
// Shared subtract-and-compare unit for the year and month walks.
module gdo_sub_unit
  import gdo_pkg::*;
(
  input  logic [21:0] minuend,
  input  logic [17:0] subtrahend,
  output logic [21:0] diff,
  output logic        fits
);

  logic [22:0] wide;

  assign wide = {1'b0, minuend} - 23'(subtrahend);
  assign diff = wide[21:0];
  assign fits = ~wide[22];

endmodule

// File: hw/rtl/gregorian_date_offset.sv
// Top level: Gregorian date plus signed day offset, iterative sequencer.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------------
//  in       | in_valid / in_stall    | start_year, start_month, start_day, day_offset
//  out      | out_valid / out_stall  | result_year, result_month, result_day, range_error
//
//  After its transfer an item passes S_FWD_Q and S_FWD_S to form the day count, then the
//  shared subtract unit walks 400-, 100-, 4- and 1-year spans and months, one step a cycle,
//  S_LEAP_Q and S_LEAP find the leap year and S_DONE loads the result.
//  Out-of-range results go from S_FWD_S to S_DONE, invalid start years from S_FWD_Q.
//  in_stall is high while an item is in work; the next item is taken while a result waits.
//  Synchronous active-low reset clears the sequencer and the output valid.
module gregorian_date_offset
  import gdo_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [13:0]        in_start_year,
  input  logic [3:0]         in_start_month,
  input  logic [4:0]         in_start_day,
  input  logic signed [20:0] in_day_offset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [13:0]        out_result_year,
  output logic [3:0]         out_result_month,
  output logic [4:0]         out_result_day,
  output logic               out_range_error
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FWD_Q  = 4'd1;
  localparam logic [3:0] S_FWD_S  = 4'd2;
  localparam logic [3:0] S_Y400   = 4'd3;
  localparam logic [3:0] S_Y100   = 4'd4;
  localparam logic [3:0] S_Y4     = 4'd5;
  localparam logic [3:0] S_Y1     = 4'd6;
  localparam logic [3:0] S_LEAP_Q = 4'd7;
  localparam logic [3:0] S_LEAP   = 4'd8;
  localparam logic [3:0] S_MON    = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]  state_r, state_nxt;
  logic [13:0] yr_r, yr_nxt;
  logic [3:0]  mo_r, mo_nxt;
  logic [4:0]  dy_r, dy_nxt;
  logic [20:0] off_r, off_nxt;
  logic [6:0]  q_r, q_nxt;
  logic [6:0]  qp_r, qp_nxt;
  logic [21:0] mul_r, mul_nxt;
  logic [21:0] z_r, z_nxt;
  logic [13:0] y_r, y_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [3:0]  mi_r, mi_nxt;
  logic        leap_r, leap_nxt;
  logic        err_r, err_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [13:0] oy_r, oy_nxt;
  logic [3:0]  om_r, om_nxt;
  logic [4:0]  od_r, od_nxt;
  logic        oe_r, oe_nxt;

  logic        in_xfer;
  logic [13:0] pm1;
  logic [13:0] div_in;
  logic [6:0]  div_q;
  logic [6:0]  divp_q;
  logic [3:0]  mo_clamp;
  logic        fwd_leap;
  logic [24:0] z_pos, z_neg, z_sum;
  logic [17:0] sub_k;
  logic [21:0] sub_diff;
  logic        sub_fits;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_result_year  = oy_r;
  assign out_result_month = om_r;
  assign out_result_day   = od_r;
  assign out_range_error  = oe_r;

  assign pm1    = yr_r - 14'd1;
  assign div_in = (state_r == S_FWD_Q) ? yr_r : y_r;

  gdo_div100 u_div_y (
    .value (div_in),
    .quot  (div_q)
  );

  gdo_div100 u_div_p (
    .value (pm1),
    .quot  (divp_q)
  );

  always_comb begin
    priority if (mo_r == 4'd0) begin
      mo_clamp = 4'd1;
    end else if (mo_r > 4'd12) begin
      mo_clamp = 4'd12;
    end else begin
      mo_clamp = mo_r;
    end
  end

  assign fwd_leap = is_leap(yr_r, q_r);
  assign z_pos = 25'(mul_r) + 25'(pm1 >> 2) + 25'(qp_r >> 2) + 25'(days_before(mo_clamp))
               + 25'(fwd_leap && (mo_clamp > 4'd2)) + 25'(dy_r);
  assign z_neg = 25'(qp_r) + 25'd1;
  assign z_sum = z_pos - z_neg + {{4{off_r[20]}}, off_r};

  always_comb begin
    unique case (state_r)
      S_Y400:  sub_k = DAYS_400Y;
      S_Y100:  sub_k = DAYS_100Y;
      S_Y4:    sub_k = DAYS_4Y;
      S_Y1:    sub_k = DAYS_1Y;
      default: sub_k = 18'(month_len(mi_r, leap_r));
    endcase
  end

  gdo_sub_unit u_sub (
    .minuend    (z_r),
    .subtrahend (sub_k),
    .diff       (sub_diff),
    .fits       (sub_fits)
  );

  always_comb begin
    state_nxt     = state_r;
    yr_nxt        = yr_r;
    mo_nxt        = mo_r;
    dy_nxt        = dy_r;
    off_nxt       = off_r;
    q_nxt         = q_r;
    qp_nxt        = qp_r;
    mul_nxt       = mul_r;
    z_nxt         = z_r;
    y_nxt         = y_r;
    cnt_nxt       = cnt_r;
    mi_nxt        = mi_r;
    leap_nxt      = leap_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    oy_nxt        = oy_r;
    om_nxt        = om_r;
    od_nxt        = od_r;
    oe_nxt        = oe_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          yr_nxt    = in_start_year;
          mo_nxt    = in_start_month;
          dy_nxt    = in_start_day;
          off_nxt   = in_day_offset;
          err_nxt   = 1'b0;
          state_nxt = S_FWD_Q;
        end
      end
      S_FWD_Q: begin
        if (yr_r == 14'd0 || yr_r > YEAR_MAX) begin
          err_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          q_nxt     = div_q;
          qp_nxt    = divp_q;
          mul_nxt   = 22'(23'(pm1) * 23'd365);
          state_nxt = S_FWD_S;
        end
      end
      S_FWD_S: begin
        if (z_sum[24] || (z_sum[23:0] >= 24'(DAY_LIMIT))) begin
          err_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          z_nxt     = z_sum[21:0];
          y_nxt     = 14'd1;
          cnt_nxt   = 2'd0;
          state_nxt = S_Y400;
        end
      end
      S_Y400: begin
        if (sub_fits) begin
          z_nxt = sub_diff;
          y_nxt = y_r + 14'd400;
        end else begin
          state_nxt = S_Y100;
        end
      end
      S_Y100: begin
        if (sub_fits && cnt_r != 2'd3) begin
          z_nxt   = sub_diff;
          y_nxt   = y_r + 14'd100;
          cnt_nxt = cnt_r + 2'd1;
        end else begin
          cnt_nxt   = 2'd0;
          state_nxt = S_Y4;
        end
      end
      S_Y4: begin
        if (sub_fits) begin
          z_nxt = sub_diff;
          y_nxt = y_r + 14'd4;
        end else begin
          state_nxt = S_Y1;
        end
      end
      S_Y1: begin
        if (sub_fits && cnt_r != 2'd3) begin
          z_nxt   = sub_diff;
          y_nxt   = y_r + 14'd1;
          cnt_nxt = cnt_r + 2'd1;
        end else begin
          state_nxt = S_LEAP_Q;
        end
      end
      S_LEAP_Q: begin
        q_nxt     = div_q;
        state_nxt = S_LEAP;
      end
      S_LEAP: begin
        leap_nxt  = is_leap(y_r, q_r);
        mi_nxt    = 4'd0;
        state_nxt = S_MON;
      end
      S_MON: begin
        if (sub_fits && mi_r != LAST_MONTH) begin
          z_nxt  = sub_diff;
          mi_nxt = mi_r + 4'd1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          oe_nxt        = err_r;
          if (err_r) begin
            oy_nxt = yr_r;
            om_nxt = mo_r;
            od_nxt = dy_r;
          end else begin
            oy_nxt = y_r;
            om_nxt = mi_r + 4'd1;
            od_nxt = z_r[4:0] + 5'd1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    yr_r   <= yr_nxt;
    mo_r   <= mo_nxt;
    dy_r   <= dy_nxt;
    off_r  <= off_nxt;
    q_r    <= q_nxt;
    qp_r   <= qp_nxt;
    mul_r  <= mul_nxt;
    z_r    <= z_nxt;
    y_r    <= y_nxt;
    cnt_r  <= cnt_nxt;
    mi_r   <= mi_nxt;
    leap_r <= leap_nxt;
    err_r  <= err_nxt;
    oy_r   <= oy_nxt;
    om_r   <= om_nxt;
    od_r   <= od_nxt;
    oe_r   <= oe_nxt;
  end

endmodule
